>>> rtl/irs_pkg.sv
// Package for the I2C register access sequencer.
// Holds the mode and action codes, the read phase encoding and the shared types.
// No dependencies.
package irs_pkg;

  localparam int unsigned LIST_DEPTH = 8;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_STATUS = 3'd2;
  localparam logic [2:0] MODE_DMA    = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  localparam logic [3:0] ACT_DATA       = 4'd0;
  localparam logic [3:0] ACT_START      = 4'd1;
  localparam logic [3:0] ACT_STOP       = 4'd2;
  localparam logic [3:0] ACT_ACK_ON     = 4'd3;
  localparam logic [3:0] ACT_ACK_OFF    = 4'd4;
  localparam logic [3:0] ACT_DMA_EN     = 4'd5;
  localparam logic [3:0] ACT_CONSUMED   = 4'd6;
  localparam logic [3:0] ACT_WRITE_DONE = 4'd7;
  localparam logic [3:0] ACT_READ_DONE  = 4'd8;
  localparam logic [3:0] ACT_ARM_DMA    = 4'd9;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_INDEX   = 4'b0010,
    PH_RESTART = 4'b0100,
    PH_RADDR   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] byte_count;
    logic        start_sent;
    logic        address_sent;
    logic        transmit_empty;
    logic        byte_finished;
    logic        ack_failure;
    logic [7:0]  next_write_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] data_value;
  } act_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    act_t [LIST_DEPTH-1:0]       entry;
  } list_t;

endpackage

>>> rtl/irs_if.sv
// Handshake interfaces for the command and action channels of the sequencer.
// Each carries valid, ready and the beat payload. No dependencies.
interface irs_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [6:0]  device_address;
  logic [7:0]  register_address;
  logic [15:0] byte_count;
  logic        start_sent;
  logic        address_sent;
  logic        transmit_empty;
  logic        byte_finished;
  logic        ack_failure;
  logic [7:0]  next_write_byte;

  modport source (
    output valid, mode, device_address, register_address, byte_count, start_sent,
           address_sent, transmit_empty, byte_finished, ack_failure, next_write_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, device_address, register_address, byte_count, start_sent,
           address_sent, transmit_empty, byte_finished, ack_failure, next_write_byte,
    output ready
  );
endinterface

interface irs_act_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] data_value;
  logic       last_action;

  modport source (output valid, action, data_value, last_action, input ready);
  modport sink (input valid, action, data_value, last_action, output ready);
endinterface

>>> rtl/irs_input_stage.sv
// Input register of the sequencer: captures one command or event beat.
// Depends on irs_pkg and irs_cmd_if.
module irs_input_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  irs_cmd_if.sink        cmd_i,
  input  logic           consume_i,
  output logic           valid_o,
  output irs_pkg::item_t item_o
);
  import irs_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign cmd_i.ready = !valid_q || consume_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (accept) begin
      item_q <= '{mode:             cmd_i.mode,
                  device_address:   cmd_i.device_address,
                  register_address: cmd_i.register_address,
                  byte_count:       cmd_i.byte_count,
                  start_sent:       cmd_i.start_sent,
                  address_sent:     cmd_i.address_sent,
                  transmit_empty:   cmd_i.transmit_empty,
                  byte_finished:    cmd_i.byte_finished,
                  ack_failure:      cmd_i.ack_failure,
                  next_write_byte:  cmd_i.next_write_byte};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

>>> rtl/irs_decode.sv
// Transaction state and action decoder of the sequencer.
// Builds the ordered action list for one beat and commits the state update.
// Depends on irs_pkg.
module irs_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  irs_pkg::item_t item_i,
  input  logic           list_free_i,
  output logic           consume_o,
  output logic           load_o,
  output irs_pkg::list_t list_o
);
  import irs_pkg::*;

  logic        wa_q, wa_d;
  logic        ra_q, ra_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  addr_q, addr_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] rlen_q, rlen_d;
  logic [15:0] wrem_q, wrem_d;
  logic [CNT_W-1:0] n;
  list_t       list;

  always_comb begin
    wa_d    = wa_q;
    ra_d    = ra_q;
    phase_d = phase_q;
    addr_d  = addr_q;
    reg_d   = reg_q;
    rlen_d  = rlen_q;
    wrem_d  = wrem_q;
    list    = '0;
    n       = '0;
    unique case (item_i.mode) inside
      MODE_WRITE, MODE_READ: begin
        addr_d = item_i.device_address;
        reg_d  = item_i.register_address;
        if (item_i.mode == MODE_WRITE) begin
          wrem_d = item_i.byte_count;
          wa_d   = 1'b1;
        end else begin
          rlen_d = item_i.byte_count;
          ra_d   = 1'b1;
          list.entry[n[IDX_W-1:0]] = '{ACT_ARM_DMA, 8'd0};
          n = n + CNT_W'(1);
        end
        list.entry[n[IDX_W-1:0]] = '{ACT_START, 8'd0};
        n = n + CNT_W'(1);
      end
      MODE_STATUS: begin
        if (item_i.start_sent) begin
          if (phase_d == PH_RESTART) begin
            list.entry[n[IDX_W-1:0]] = '{ACT_DATA, {addr_q, 1'b1}};
            phase_d = PH_RADDR;
          end else begin
            list.entry[n[IDX_W-1:0]] = '{ACT_DATA, {addr_q, 1'b0}};
          end
          n = n + CNT_W'(1);
        end
        if (item_i.address_sent) begin
          if (phase_d == PH_RADDR) begin
            if (rlen_q == 16'd1) begin
              phase_d = PH_IDLE;
              list.entry[n[IDX_W-1:0]] = '{ACT_ACK_OFF, 8'd0};
              n = n + CNT_W'(1);
              list.entry[n[IDX_W-1:0]] = '{ACT_STOP, 8'd0};
              n = n + CNT_W'(1);
            end else begin
              list.entry[n[IDX_W-1:0]] = '{ACT_ACK_ON, 8'd0};
              n = n + CNT_W'(1);
              list.entry[n[IDX_W-1:0]] = '{ACT_DMA_EN, 8'd0};
              n = n + CNT_W'(1);
            end
          end else begin
            if (wa_q) begin
              list.entry[n[IDX_W-1:0]] = '{ACT_DATA, reg_q};
              n = n + CNT_W'(1);
            end
            if (ra_q) begin
              list.entry[n[IDX_W-1:0]] = '{ACT_DATA, reg_q};
              n = n + CNT_W'(1);
              phase_d = PH_INDEX;
            end
          end
        end
        if (item_i.transmit_empty && wa_q && (wrem_q != 16'd0)) begin
          list.entry[n[IDX_W-1:0]] = '{ACT_DATA, item_i.next_write_byte};
          n = n + CNT_W'(1);
          list.entry[n[IDX_W-1:0]] = '{ACT_CONSUMED, 8'd0};
          n = n + CNT_W'(1);
          wrem_d = wrem_q - 16'd1;
        end
        if (item_i.byte_finished) begin
          if (phase_d == PH_INDEX) begin
            list.entry[n[IDX_W-1:0]] = '{ACT_START, 8'd0};
            n = n + CNT_W'(1);
            phase_d = PH_RESTART;
          end
          if (wa_q && (wrem_d == 16'd0)) begin
            list.entry[n[IDX_W-1:0]] = '{ACT_STOP, 8'd0};
            n = n + CNT_W'(1);
            list.entry[n[IDX_W-1:0]] = '{ACT_WRITE_DONE, 8'd0};
            n = n + CNT_W'(1);
            wa_d = 1'b0;
          end
        end
      end
      MODE_DMA: begin
        list.entry[n[IDX_W-1:0]] = '{ACT_STOP, 8'd0};
        n = n + CNT_W'(1);
        list.entry[n[IDX_W-1:0]] = '{ACT_READ_DONE, 8'd0};
        n = n + CNT_W'(1);
        ra_d    = 1'b0;
        phase_d = PH_IDLE;
      end
      MODE_ERROR: begin
        if (item_i.ack_failure) begin
          list.entry[n[IDX_W-1:0]] = '{ACT_STOP, 8'd0};
          n = n + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    list.count = n;
  end

  assign consume_o = valid_i && ((n == '0) || list_free_i);
  assign load_o    = consume_o && (n != '0);
  assign list_o    = list;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q    <= 1'b0;
      ra_q    <= 1'b0;
      phase_q <= PH_IDLE;
      addr_q  <= '0;
      reg_q   <= '0;
      rlen_q  <= '0;
      wrem_q  <= '0;
    end else if (consume_o) begin
      wa_q    <= wa_d;
      ra_q    <= ra_d;
      phase_q <= phase_d;
      addr_q  <= addr_d;
      reg_q   <= reg_d;
      rlen_q  <= rlen_d;
      wrem_q  <= wrem_d;
    end
  end
endmodule

>>> rtl/irs_action_queue.sv
// Action list register of the sequencer: shifts out one action per beat.
// Depends on irs_pkg and irs_act_if.
module irs_action_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  irs_pkg::list_t list_i,
  output logic           list_free_o,
  irs_act_if.source      act_o
);
  import irs_pkg::*;

  logic [CNT_W-1:0]      count_q;
  act_t [LIST_DEPTH-1:0] entry_q;
  logic                  take;

  assign take        = (count_q != '0) && act_o.ready;
  assign list_free_o = (count_q == '0) || (take && (count_q == CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_i) begin
      count_q <= list_i.count;
    end else if (take) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= list_i.entry;
    end else if (take) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        entry_q[i] <= entry_q[i+1];
      end
      entry_q[LIST_DEPTH-1] <= '0;
    end
  end

  assign act_o.valid       = (count_q != '0);
  assign act_o.action      = entry_q[0].action;
  assign act_o.data_value  = entry_q[0].data_value;
  assign act_o.last_action = (count_q == CNT_W'(1));
endmodule

>>> rtl/i2c_register_access_sequencer_unit.sv
// I2C register access sequencer: turns command and status beats into action beats.
// Throughput: one action beat per cycle while act_o.ready is high; a beat with
// several actions holds the action register until all are taken, beats with at
// most one action are taken every cycle.
// Reset clears the transaction flags, read phase, stored address and counts, and
// empties the input and action registers. Depends on irs_pkg and irs_if.
module i2c_register_access_sequencer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  irs_cmd_if.sink   cmd_i,
  irs_act_if.source act_o
);
  import irs_pkg::*;

  logic  item_valid;
  item_t item;
  logic  consume;
  logic  load;
  logic  list_free;
  list_t list;

  irs_input_stage u_input (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .consume_i (consume),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  irs_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item),
    .list_free_i (list_free),
    .consume_o   (consume),
    .load_o      (load),
    .list_o      (list)
  );

  irs_action_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .list_i      (list),
    .list_free_o (list_free),
    .act_o       (act_o)
  );

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_o.valid && (act_o.action != ACT_DATA)) |-> (act_o.data_value == 8'd0))
    else $error("Non-data action carries a nonzero byte.");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_o.valid && act_o.ready && act_o.last_action && !load) |=> !act_o.valid)
    else $error("Action register still valid after its last beat.");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> list_free)
    else $error("Action list loaded while earlier actions remain.");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid |-> cmd_i.ready)
    else $error("Input stalled while the input register is empty.");

endmodule
